### src/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file but spq_pos_enc takes names from here by scope.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

  // what each cell does on the update cycle
  typedef enum logic [1:0] {
    UPD_HOLD,
    UPD_INSERT,
    UPD_REMOVE
  } spq_upd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_RES
  } spq_state_e;

  // compare flags of one cell, registered on the compare cycle
  //   t: empty slot or stored value >= operand
  //   g: occupied and stored value >= operand
  //   e: occupied and stored value == operand
  typedef struct packed {
    logic t;
    logic g;
    logic e;
  } spq_flags_t;

endpackage

### src/spq_if.sv
// Valid/ready channel interfaces for operations and results.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps

interface spq_in_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::KIND_W-1:0]          kind;
  logic signed [spq_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface spq_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic [spq_pkg::POS_W-1:0]           position;
  logic [spq_pkg::COUNT_W-1:0]         count;
  logic                                head_valid;
  logic signed [spq_pkg::VALUE_W-1:0]  head_value;

  modport source (output valid, output ok, output position, output count,
                  output head_valid, output head_value, input ready);
  modport sink   (input valid, input ok, input position, input count,
                  input head_valid, input head_value, output ready);
endinterface

### src/spq_cell.sv
// One slot of the sorted chain: value, occupancy bit and compare flags.
// Depends on spq_pkg; shifts data to or from its neighbours on update.
`timescale 1ns / 1ps

module spq_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [spq_pkg::VALUE_W-1:0]  operand_i,
  input  logic                                cmp_i,
  input  spq_pkg::spq_upd_e                   upd_i,
  input  logic                                left_t_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  left_val_i,
  input  logic                                left_vld_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]  right_val_i,
  input  logic                                right_vld_i,
  output spq_pkg::spq_flags_t                 flags_o,
  output logic signed [spq_pkg::VALUE_W-1:0]  val_o,
  output logic                                vld_o
);

  logic signed [spq_pkg::VALUE_W-1:0] val_q, val_d;
  logic                               vld_q, vld_d;
  spq_pkg::spq_flags_t                flags_q, flags_d;
  logic                               ge;
  logic                               eq;

  assign ge = (val_q >= operand_i);
  assign eq = (val_q == operand_i);

  always_comb begin
    flags_d = flags_q;
    if (cmp_i) begin
      flags_d.t = ~vld_q | ge;
      flags_d.g = vld_q & ge;
      flags_d.e = vld_q & eq;
    end
  end

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    unique case (upd_i)
      spq_pkg::UPD_INSERT: begin
        if (flags_q.t) begin
          if (left_t_i) begin
            // make room: take the neighbour's entry
            val_d = left_val_i;
            vld_d = left_vld_i;
          end else begin
            val_d = operand_i;
            vld_d = 1'b1;
          end
        end
      end
      spq_pkg::UPD_REMOVE: begin
        // close the gap from the right
        if (flags_q.g) begin
          val_d = right_val_i;
          vld_d = right_vld_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      flags_q <= '0;
    end else begin
      vld_q   <= vld_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign flags_o = flags_q;
  assign val_o   = val_q;
  assign vld_o   = vld_q;

endmodule

### src/spq_pos_enc.sv
// One-hot to index encoder for the position of the first hit in the chain.
// No dependencies.
`timescale 1ns / 1ps

module spq_pos_enc #(
  parameter int unsigned N     = 16,
  parameter int unsigned IDX_W = $clog2(N)
) (
  input  logic [N-1:0]     hot_i,
  output logic [IDX_W-1:0] idx_o
);

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < N; i++) begin
      if (hot_i[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

endmodule

### src/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of CAPACITY cells with broadcast compare.
// An accepted operation passes the compare, update and result states in order;
// the result state waits for a free output register, loads it and returns to idle.
// Operations are taken only in idle; a pending result may hold the output register.
// Reset: asynchronous, active low; empties the queue (occupancy bits and count).
`timescale 1ns / 1ps

module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     in_i,
  spq_out_if.source  out_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::spq_state_e                 state_q, state_d;
  logic [spq_pkg::KIND_W-1:0]          kind_q;
  logic signed [spq_pkg::VALUE_W-1:0]  operand_q;
  logic [CNT_W-1:0]                    count_q, count_d;
  logic                                res_ok_q, res_ok_d;
  logic [IDX_W-1:0]                    res_pos_q, res_pos_d;

  logic                                out_vld_q, out_vld_d;
  logic                                out_ok_q;
  logic [spq_pkg::POS_W-1:0]           out_pos_q;
  logic [spq_pkg::COUNT_W-1:0]         out_cnt_q;
  logic                                out_hv_q;
  logic signed [spq_pkg::VALUE_W-1:0]  out_hval_q;

  spq_pkg::spq_flags_t                 flags [CAPACITY];
  logic signed [spq_pkg::VALUE_W-1:0]  vals  [CAPACITY];
  logic [CAPACITY-1:0]                 vld;
  logic [CAPACITY-1:0]                 t_vec, e_vec;
  logic [CAPACITY-1:0]                 hot;
  logic [IDX_W-1:0]                    hit_idx;

  logic                                cmp;
  spq_pkg::spq_upd_e                   upd;
  logic                                full;
  logic                                found;
  logic                                in_acc;
  logic                                res_load;
  logic [IDX_W+spq_pkg::POS_W-1:0]     pos_ext;
  logic [CNT_W+spq_pkg::COUNT_W-1:0]   cnt_ext;

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               left_t;
    logic signed [spq_pkg::VALUE_W-1:0] left_val;
    logic                               left_vld;
    logic signed [spq_pkg::VALUE_W-1:0] right_val;
    logic                               right_vld;

    if (i == 0) begin : g_first
      assign left_t   = 1'b0;
      assign left_val = operand_q;
      assign left_vld = 1'b0;
    end else begin : g_mid_l
      assign left_t   = flags[i-1].t;
      assign left_val = vals[i-1];
      assign left_vld = vld[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid_r
      assign right_val = vals[i+1];
      assign right_vld = vld[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .operand_i   (operand_q),
      .cmp_i       (cmp),
      .upd_i       (upd),
      .left_t_i    (left_t),
      .left_val_i  (left_val),
      .left_vld_i  (left_vld),
      .right_val_i (right_val),
      .right_vld_i (right_vld),
      .flags_o     (flags[i]),
      .val_o       (vals[i]),
      .vld_o       (vld[i])
    );

    assign t_vec[i] = flags[i].t;
    assign e_vec[i] = flags[i].e;
  end

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign found = |e_vec;

  // first set flag: insert slot or first equal entry
  always_comb begin
    if (kind_q == spq_pkg::KIND_INSERT) begin
      hot = t_vec & ~{t_vec[CAPACITY-2:0], 1'b0};
    end else begin
      hot = e_vec & ~{e_vec[CAPACITY-2:0], 1'b0};
    end
  end

  spq_pos_enc #(
    .N     (CAPACITY),
    .IDX_W (IDX_W)
  ) u_pos_enc (
    .hot_i (hot),
    .idx_o (hit_idx)
  );

  assign in_acc   = in_i.valid & in_i.ready;
  assign res_load = (state_q == spq_pkg::ST_RES) & (~out_vld_q | out_o.ready);

  always_comb begin
    state_d   = state_q;
    cmp       = 1'b0;
    upd       = spq_pkg::UPD_HOLD;
    count_d   = count_q;
    res_ok_d  = res_ok_q;
    res_pos_d = res_pos_q;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = spq_pkg::ST_CMP;
        end
      end
      spq_pkg::ST_CMP: begin
        cmp     = 1'b1;
        state_d = spq_pkg::ST_UPD;
      end
      spq_pkg::ST_UPD: begin
        res_ok_d = 1'b0;
        priority if (kind_q == spq_pkg::KIND_INSERT) begin
          if (!full) begin
            upd      = spq_pkg::UPD_INSERT;
            res_ok_d = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end else if (kind_q == spq_pkg::KIND_REMOVE) begin
          if (found) begin
            upd      = spq_pkg::UPD_REMOVE;
            res_ok_d = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end else if (kind_q == spq_pkg::KIND_FIND) begin
          res_ok_d = found;
        end else begin
          res_ok_d = 1'b0;
        end
        res_pos_d = res_ok_d ? hit_idx : '0;
        state_d   = spq_pkg::ST_RES;
      end
      spq_pkg::ST_RES: begin
        if (res_load) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_load) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spq_pkg::ST_IDLE;
      count_q   <= '0;
      res_ok_q  <= 1'b0;
      res_pos_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_ok_q  <= res_ok_d;
      res_pos_q <= res_pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  // hold the operation for the compare and update cycles
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= in_i.kind;
      operand_q <= in_i.value;
    end
  end

  assign pos_ext = (IDX_W + spq_pkg::POS_W)'(res_pos_q);
  assign cnt_ext = (CNT_W + spq_pkg::COUNT_W)'(count_q);

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_ok_q   <= res_ok_q;
      out_pos_q  <= pos_ext[spq_pkg::POS_W-1:0];
      out_cnt_q  <= cnt_ext[spq_pkg::COUNT_W-1:0];
      out_hv_q   <= vld[0];
      out_hval_q <= vld[0] ? vals[0] : '0;
    end
  end

  assign in_i.ready       = (state_q == spq_pkg::ST_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.ok         = out_ok_q;
  assign out_o.position   = out_pos_q;
  assign out_o.count      = out_cnt_q;
  assign out_o.head_valid = out_hv_q;
  assign out_o.head_value = out_hval_q;

  // occupancy bits always agree with the element count
  a_count_matches_cells: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(vld) == int'(count_q)
  ) else $error("occupied cells disagree with element count");

  a_count_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY)
  ) else $error("element count above capacity");

  a_pos_zero_on_miss: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ok) |-> (out_o.position == '0)
  ) else $error("position not zero on a failed operation");

  a_head_matches_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.head_valid == (out_o.count != '0))
  ) else $error("head valid disagrees with reported count");

endmodule

### tb/sv/tb_sorted_priority_queue_unit.sv
// Self-checking bench for sorted_priority_queue_unit: directed table, then random traffic.
// Needs spq_pkg, spq_in_if/spq_out_if and the unit itself; results are checked
// against a shadow of the sorted store kept in this file.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;

  localparam int unsigned CAPACITY        = 16;
  localparam int          N_RANDOM        = 1620;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          HOLD_OFF_AT     = 400;
  localparam int          DRAIN_AT        = 900;
  localparam int          TAIL_CYCLES     = 12;
  localparam int          WATCHDOG_LIMIT  = 2000;

  localparam logic [spq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic signed [spq_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [spq_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                                ok;
    logic [spq_pkg::POS_W-1:0]           position;
    logic [spq_pkg::COUNT_W-1:0]         count;
    logic                                head_valid;
    logic signed [spq_pkg::VALUE_W-1:0]  head_value;
  } queue_status_t;

  // a status typed in by hand overrides the status predicted from the shadow store for that transaction
  typedef struct {
    bit            pinned;
    queue_status_t status;
  } status_note_t;

  typedef struct {
    logic [spq_pkg::KIND_W-1:0]         kind;
    logic signed [spq_pkg::VALUE_W-1:0] operand;
    bit                                 pinned;
    queue_status_t                      status;
  } op_row_t;

  typedef enum int {
    SINK_STEADY,
    SINK_COIN,
    SINK_PATTERN,
    SINK_SPARSE
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  op_if ();
  spq_out_if st_if ();

  sorted_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (st_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int             shadow_store[$];
  queue_status_t  status_due[$];
  status_note_t   pinned_notes[$];
  int             sent_pool[$];
  int             mismatches = 0;
  int             idle_cycles = 0;
  bit             hold_off_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow of the sorted store
  // ---------------------------------------------------------------------------

  function automatic queue_status_t apply_queue_op(
      input logic [spq_pkg::KIND_W-1:0] kind,
      input logic signed [spq_pkg::VALUE_W-1:0] operand);
    queue_status_t st;
    int unsigned   slot;
    int            idx;
    bit            placed;
    bit            hit;
    st     = '0;
    slot   = 0;
    placed = 1'b0;
    hit    = 1'b0;
    case (kind)
      spq_pkg::KIND_INSERT: begin
        if (shadow_store.size() < CAPACITY) begin
          slot = shadow_store.size();
          // go before the first value that is greater or equal
          for (idx = 0; idx < shadow_store.size(); idx++) begin
            if (!placed && shadow_store[idx] >= operand) begin
              slot   = idx;
              placed = 1'b1;
            end
          end
          shadow_store.insert(slot, operand);
          hit = 1'b1;
        end
      end
      spq_pkg::KIND_REMOVE, spq_pkg::KIND_FIND: begin
        for (idx = 0; idx < shadow_store.size(); idx++) begin
          if (!hit && shadow_store[idx] == operand) begin
            slot = idx;
            hit  = 1'b1;
          end
        end
        if (hit && kind == spq_pkg::KIND_REMOVE) shadow_store.delete(slot);
      end
      default: ;
    endcase
    st.ok         = hit;
    st.position   = hit ? spq_pkg::POS_W'(slot) : '0;
    st.count      = spq_pkg::COUNT_W'(shadow_store.size());
    st.head_valid = shadow_store.size() > 0;
    st.head_value = (shadow_store.size() > 0) ? shadow_store[0] : '0;
    return st;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] wanted,
                             input logic signed [63:0] seen);
    if (seen !== wanted) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, wanted, seen);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on accepted operations, compare accepted statuses
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : scoreboard
    queue_status_t predicted;
    queue_status_t wanted;
    status_note_t  note;
    if (rst_ni) begin
      if (op_if.valid && op_if.ready) begin
        predicted = apply_queue_op(op_if.kind, op_if.value);
        note      = pinned_notes.pop_front();
        status_due.push_back(note.pinned ? note.status : predicted);
      end
      if (st_if.valid && st_if.ready) begin
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: status transaction with nothing expected, count %0d head %0d",
                   $time, st_if.count, st_if.head_value);
        end else begin
          wanted = status_due.pop_front();
          check_field("ok", wanted.ok, st_if.ok);
          check_field("position", wanted.position, st_if.position);
          check_field("count", wanted.count, st_if.count);
          check_field("head_valid", wanted.head_valid, st_if.head_valid);
          check_field("head_value", wanted.head_value, st_if.head_value);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((op_if.valid && op_if.ready) || (st_if.valid && st_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Status receiver: stalls on its own pattern, long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    sink_mode_e mode;
    int         seg;
    int         i;
    st_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        for (i = 0; i < HOLD_OFF_CYCLES; i++) begin
          @(posedge clk_i);
          st_if.ready <= 1'b0;
        end
        hold_off_req = 1'b0;
      end else begin
        mode = sink_mode_e'($urandom_range(0, 3));
        seg  = $urandom_range(10, 120);
        for (i = 0; i < seg && !hold_off_req; i++) begin
          @(posedge clk_i);
          case (mode)
            SINK_STEADY:  st_if.ready <= 1'b1;
            SINK_COIN:    st_if.ready <= $urandom_range(0, 1);
            SINK_PATTERN: st_if.ready <= (i % 5) < 2;
            default:      st_if.ready <= $urandom_range(0, 9) != 0;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Operation sender
  // ---------------------------------------------------------------------------

  task automatic offer_op(input logic [spq_pkg::KIND_W-1:0] kind,
                          input logic signed [spq_pkg::VALUE_W-1:0] operand,
                          input bit pinned, input queue_status_t status);
    status_note_t note;
    note.pinned = pinned;
    note.status = status;
    pinned_notes.push_back(note);
    if (kind == spq_pkg::KIND_INSERT) begin
      sent_pool.push_back(operand);
      if (sent_pool.size() > 32) void'(sent_pool.pop_front());
    end
    op_if.valid <= 1'b1;
    op_if.kind  <= kind;
    op_if.value <= operand;
    do @(posedge clk_i); while (!op_if.ready);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      op_if.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic op_row_t free_row(input logic [spq_pkg::KIND_W-1:0] kind,
                                       input logic signed [spq_pkg::VALUE_W-1:0] operand);
    op_row_t row;
    row.kind    = kind;
    row.operand = operand;
    row.pinned  = 1'b0;
    row.status  = '0;
    return row;
  endfunction

  function automatic op_row_t pinned_row(input logic [spq_pkg::KIND_W-1:0] kind,
                                         input logic signed [spq_pkg::VALUE_W-1:0] operand,
                                         input logic ok, input int unsigned pos,
                                         input int unsigned cnt, input logic hv,
                                         input logic signed [spq_pkg::VALUE_W-1:0] head);
    op_row_t row;
    row.kind              = kind;
    row.operand           = operand;
    row.pinned            = 1'b1;
    row.status.ok         = ok;
    row.status.position   = spq_pkg::POS_W'(pos);
    row.status.count      = spq_pkg::COUNT_W'(cnt);
    row.status.head_valid = hv;
    row.status.head_value = head;
    return row;
  endfunction

  function automatic logic signed [spq_pkg::VALUE_W-1:0] draw_operand(input bit from_pool);
    int r;
    r = $urandom_range(0, 99);
    if (from_pool && sent_pool.size() > 0 && r < 60) begin
      return sent_pool[$urandom_range(0, sent_pool.size() - 1)];
    end else if (r < 75) begin
      return int'($urandom_range(0, 16)) - 8;
    end else if (r < 82) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : sender
    op_row_t                            rows[$];
    int                                 fill_vals[13];
    int                                 n;
    int                                 burst;
    int                                 r;
    bit                                 fill_phase;
    logic [spq_pkg::KIND_W-1:0]         kind;
    logic signed [spq_pkg::VALUE_W-1:0] operand;

    op_if.valid <= 1'b0;
    op_if.kind  <= spq_pkg::KIND_INSERT;
    op_if.value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, extremes, equal values, missing values, an unused kind, full store
    rows.push_back(pinned_row(spq_pkg::KIND_FIND,   0,       0, 0, 0, 0, 0));
    rows.push_back(pinned_row(spq_pkg::KIND_REMOVE, 0,       0, 0, 0, 0, 0));
    rows.push_back(pinned_row(KIND_UNUSED,          -1,      0, 0, 0, 0, 0));
    rows.push_back(pinned_row(spq_pkg::KIND_INSERT, VAL_MAX, 1, 0, 1, 1, VAL_MAX));
    rows.push_back(pinned_row(spq_pkg::KIND_INSERT, VAL_MIN, 1, 0, 2, 1, VAL_MIN));
    rows.push_back(free_row(spq_pkg::KIND_INSERT, 0));
    rows.push_back(free_row(spq_pkg::KIND_INSERT, 0));
    rows.push_back(free_row(spq_pkg::KIND_FIND, 0));
    rows.push_back(free_row(spq_pkg::KIND_FIND, VAL_MAX));
    rows.push_back(free_row(spq_pkg::KIND_REMOVE, 0));
    rows.push_back(pinned_row(spq_pkg::KIND_REMOVE, 5,       0, 0, 3, 1, VAL_MIN));
    fill_vals = '{-40, 77, -3, 0, 5, 5, 1000, -1000, 3, 32'h1234, -7, 9, 2};
    foreach (fill_vals[n]) rows.push_back(free_row(spq_pkg::KIND_INSERT, fill_vals[n]));
    rows.push_back(pinned_row(spq_pkg::KIND_INSERT, 12345,   0, 0, 16, 1, VAL_MIN));
    rows.push_back(free_row(spq_pkg::KIND_FIND, VAL_MAX));
    rows.push_back(free_row(spq_pkg::KIND_REMOVE, VAL_MAX));
    rows.push_back(free_row(spq_pkg::KIND_REMOVE, VAL_MIN));

    foreach (rows[n]) begin
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
      offer_op(rows[n].kind, rows[n].operand, rows[n].pinned, rows[n].status);
    end

    burst = 0;
    for (n = 0; n < N_RANDOM; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 9) >= 3) idle_gap($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
      // keep offering while the receiver holds off, so the unit backs up
      if (n == HOLD_OFF_AT) hold_off_req = 1'b1;
      if (n == DRAIN_AT) begin
        op_if.valid <= 1'b0;
        do @(posedge clk_i); while (status_due.size() != 0);
      end

      // alternate fill-biased and drain-biased stretches to visit every count
      fill_phase = ((n / 64) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        kind = KIND_UNUSED;
      end else if (fill_phase) begin
        kind = (r < 63) ? spq_pkg::KIND_INSERT :
               (r < 83) ? spq_pkg::KIND_REMOVE : spq_pkg::KIND_FIND;
      end else begin
        kind = (r < 23) ? spq_pkg::KIND_INSERT :
               (r < 78) ? spq_pkg::KIND_REMOVE : spq_pkg::KIND_FIND;
      end
      operand = draw_operand(kind != spq_pkg::KIND_INSERT);
      offer_op(kind, operand, 1'b0, '0);
      burst--;
    end

    op_if.valid <= 1'b0;
    // the last transaction is logged at a clock edge, so wait for an edge before checking
    do @(posedge clk_i); while (status_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
